### rtl/core/xvse_pkg.sv
package xvse_pkg;

  localparam int VALUE_BITS = 64;
  localparam int CNT_W      = 7;    // holds a zero count of 0..VALUE_BITS
  localparam int SAMPLE_W   = 32;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 32;
  localparam int RAW_BITS_W = 7;
  localparam int HDR_BITS   = 13;

  localparam logic [RAW_BITS_W-1:0] RAW_BITS_RESET = 7'd32;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_SKIP_GAPS     = 2'd0,
    REG_GAP_FILL      = 2'd1,
    REG_SAMPLE_OFFSET = 2'd2,
    REG_RAW_BITS      = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic                  skip_gaps;
    logic [SAMPLE_W-1:0]   gap_fill;
    logic [SAMPLE_W-1:0]   sample_offset;
    logic [RAW_BITS_W-1:0] raw_bits;
  } cfg_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                is_no_data;
    logic                column_start;
  } item_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] prev_value;
    logic [CNT_W-1:0]      prev_leading;
    logic [CNT_W-1:0]      prev_trailing;
    logic                  have_first;
  } state_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] chunk;
    logic [CNT_W-1:0]      chunk_len;
    logic                  last;
    logic                  range_error;
  } result_t;

  typedef struct packed {
    result_t     first;
    result_t     second;
    logic [1:0]  count;   // 0, 1 or 2 results
    state_t      state_next;
  } code_t;

endpackage

### rtl/core/xvse_code.sv
module xvse_code (
  input  xvse_pkg::cfg_t   cfg,
  input  xvse_pkg::state_t state,
  input  xvse_pkg::item_t  item,
  output xvse_pkg::code_t  code
);
  import xvse_pkg::*;

  function automatic logic [CNT_W-1:0] lead_zeros(input logic [VALUE_BITS-1:0] x);
    logic [CNT_W-1:0] n;
    n = CNT_W'(VALUE_BITS);
    for (int i = 0; i < VALUE_BITS; i++) begin
      if (x[i]) n = CNT_W'(VALUE_BITS - 1 - i);
    end
    return n;
  endfunction

  function automatic logic [CNT_W-1:0] trail_zeros(input logic [VALUE_BITS-1:0] x);
    logic [CNT_W-1:0] n;
    n = CNT_W'(VALUE_BITS);
    for (int i = VALUE_BITS - 1; i >= 0; i--) begin
      if (x[i]) n = CNT_W'(i);
    end
    return n;
  endfunction

  logic                  have_eff;
  logic                  skip;
  logic [SAMPLE_W-1:0]   selected;
  logic [SAMPLE_W:0]     sum;
  logic                  negative;
  logic [VALUE_BITS-1:0] v;
  logic [VALUE_BITS-1:0] x;
  logic [VALUE_BITS-1:0] count_in;
  logic [CNT_W-1:0]      lz_raw;
  logic [CNT_W-1:0]      tz;
  logic [CNT_W-1:0]      lz;
  logic [CNT_W:0]        blk;
  logic [CNT_W:0]        win_sum;
  logic [CNT_W:0]        psize;
  logic                  use_window;
  logic [CNT_W-1:0]      rb;
  logic [VALUE_BITS-1:0] raw_mask;
  logic [CNT_W-1:0]      blk_m1;

  always_comb begin
    have_eff = state.have_first && !item.column_start;
    skip     = item.is_no_data && cfg.skip_gaps;
    selected = item.is_no_data ? cfg.gap_fill : item.sample;
    sum      = {selected[SAMPLE_W-1], selected}
             + {cfg.sample_offset[SAMPLE_W-1], cfg.sample_offset};
    negative = sum[SAMPLE_W];
    v        = VALUE_BITS'(sum);
    x        = state.prev_value ^ v;

    // One pair of zero counters serves both the raw value and the XOR.
    count_in = have_eff ? x : v;
    lz_raw   = lead_zeros(count_in);
    tz       = trail_zeros(count_in);
    lz       = (lz_raw > CNT_W'(31)) ? CNT_W'(31) : lz_raw;
    blk      = (CNT_W+1)'(VALUE_BITS) - {1'b0, lz} - {1'b0, tz};
    blk_m1   = CNT_W'(blk - (CNT_W+1)'(1));

    win_sum  = {1'b0, state.prev_leading} + {1'b0, state.prev_trailing};
    psize    = (CNT_W+1)'(VALUE_BITS) - win_sum;
    use_window = (win_sum < (CNT_W+1)'(VALUE_BITS))
              && (lz >= state.prev_leading) && (tz >= state.prev_trailing)
              && (psize < blk + (CNT_W+1)'(11));

    if (cfg.raw_bits == '0) begin
      rb = CNT_W'(1);
    end else if (cfg.raw_bits > RAW_BITS_W'(VALUE_BITS)) begin
      rb = CNT_W'(VALUE_BITS);
    end else begin
      rb = CNT_W'(cfg.raw_bits);
    end
    raw_mask = (rb >= CNT_W'(VALUE_BITS)) ? '1
             : ((VALUE_BITS'(1) << rb) - VALUE_BITS'(1));

    code.first      = '0;
    code.second     = '0;
    code.count      = 2'd0;
    code.state_next = state;
    code.state_next.have_first = have_eff;

    if (skip) begin
      code.count = 2'd0;
    end else if (negative) begin
      code.count             = 2'd1;
      code.first.last        = 1'b1;
      code.first.range_error = 1'b1;
    end else if (!have_eff) begin
      code.count                    = 2'd1;
      code.first.chunk              = v & raw_mask;
      code.first.chunk_len          = rb;
      code.first.last               = 1'b1;
      code.state_next.have_first    = 1'b1;
      code.state_next.prev_value    = v;
      code.state_next.prev_leading  = lz_raw;
      code.state_next.prev_trailing = tz;
    end else if (x == '0) begin
      code.count           = 2'd1;
      code.first.chunk_len = CNT_W'(1);
      code.first.last      = 1'b1;
    end else begin
      code.count                 = 2'd2;
      code.second.last           = 1'b1;
      code.state_next.prev_value = v;
      if (use_window) begin
        code.first.chunk      = VALUE_BITS'(3);
        code.first.chunk_len  = CNT_W'(2);
        code.second.chunk     = x >> state.prev_trailing;
        code.second.chunk_len = CNT_W'(psize);
      end else begin
        code.first.chunk      = VALUE_BITS'({2'b10, lz[4:0], blk_m1[5:0]});
        code.first.chunk_len  = CNT_W'(HDR_BITS);
        code.second.chunk     = x >> tz;
        code.second.chunk_len = CNT_W'(blk);
        code.state_next.prev_leading  = lz;
        code.state_next.prev_trailing = tz;
      end
    end
  end

endmodule

### rtl/core/xor_value_stream_encoder.sv
// Channel   Direction  Transaction contents
// s_*       in         tdata: sample; tuser: is_no_data, column_start
// m_*       out        tdata: chunk, chunk_len; tlast: last; tuser: range_error
// cfg_*     in         register index and data, taken when cfg_we is high
//
// A sample passes an input register, is coded combinationally and leaves through a
// two-entry result stage. A sample that codes to two chunks holds the result channel
// until both have left, and the next sample enters only as the second one leaves;
// for single-chunk codes the sustained rate is one sample per cycle while m_tready
// is high. Skipped no-data samples produce no result.
// Reset is synchronous and resets config, valid flags and state, but not the data registers.
// Stalls on the result side back up into the input register and then s_tready.
module xor_value_stream_encoder (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [xvse_pkg::SAMPLE_W-1:0]      s_tdata,   // [31:0] sample
  input  logic [1:0]                         s_tuser,   // [0] is_no_data, [1] column_start
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [71:0]                        m_tdata,   // [63:0] chunk, [70:64] chunk_len
  output logic                               m_tlast,
  output logic                               m_tuser,   // [0] range_error
  input  logic                               cfg_we,
  input  logic [xvse_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [xvse_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import xvse_pkg::*;

  cfg_t    cfg;
  state_t  state;
  item_t   item;
  logic    item_valid;
  code_t   code;
  result_t out_res;
  logic    out_valid;
  result_t held_res;
  logic    held_valid;
  logic    free;
  logic    item_move;

  xvse_code u_code (
    .cfg   (cfg),
    .state (state),
    .item  (item),
    .code  (code)
  );

  // The result stage can take a new item's results when it is empty, or when
  // its only remaining result is leaving this cycle.
  assign free      = !out_valid || (m_tready && !held_valid);
  assign item_move = item_valid && free;
  assign s_tready  = !item_valid || item_move;

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_res.chunk_len, out_res.chunk};
  assign m_tlast  = out_res.last;
  assign m_tuser  = out_res.range_error;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.skip_gaps     <= 1'b0;
      cfg.gap_fill      <= '0;
      cfg.sample_offset <= '0;
      cfg.raw_bits      <= RAW_BITS_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_SKIP_GAPS:     cfg.skip_gaps     <= cfg_wdata[0];
        REG_GAP_FILL:      cfg.gap_fill      <= cfg_wdata;
        REG_SAMPLE_OFFSET: cfg.sample_offset <= cfg_wdata;
        REG_RAW_BITS:      cfg.raw_bits      <= cfg_wdata[RAW_BITS_W-1:0];
        default:           cfg.skip_gaps     <= cfg.skip_gaps;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      out_valid  <= 1'b0;
      held_valid <= 1'b0;
      state      <= '0;
    end else begin
      if (s_tready) begin
        item_valid <= s_tvalid;
      end
      // A new item only enters when the stage is empty or its last result
      // leaves now, so it replaces the stage contents outright.
      if (item_move) begin
        state      <= code.state_next;
        out_valid  <= (code.count != 2'd0);
        held_valid <= (code.count == 2'd2);
      end else if (out_valid && m_tready) begin
        if (held_valid) begin
          held_valid <= 1'b0;
        end else begin
          out_valid <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      item.sample       <= s_tdata;
      item.is_no_data   <= s_tuser[0];
      item.column_start <= s_tuser[1];
    end
    if (item_move) begin
      if (code.count != 2'd0) begin
        out_res  <= code.first;
        held_res <= code.second;
      end
    end else if (out_valid && m_tready && held_valid) begin
      out_res <= held_res;
    end
  end

  a_held_needs_out: assert property (@(posedge clk) disable iff (rst)
    held_valid |-> out_valid)
    else $error("second chunk held without a first chunk on the output");

  a_error_is_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tlast && m_tdata[63:0] == 64'd0))
    else $error("range error result is not a single empty last chunk");

  a_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata[70:64] != 7'd0))
    else $error("coded chunk with zero length");

  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    (held_valid && m_tready) |=> (out_valid && out_res.last))
    else $error("second chunk of a pair did not follow the first");

endmodule
